### design/dha_pkg.sv
// ----------------------------------------------------------------------------
// dha_pkg - shared types and constants of the drum hit analyser
// Field widths, fixed arithmetic constants, the job descriptor that passes
// from the loader to the scan engine, and the scan state encoding.
// ----------------------------------------------------------------------------
package dha_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Widest values the parameter ranges allow
  localparam int unsigned IDX_W_MAX = 20;
  localparam int unsigned CNT_W_MAX = IDX_W_MAX + 1;
  localparam int unsigned SMP_W_MAX = 32;

  localparam int unsigned RATE_W   = 18;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  localparam int unsigned XTOT_W  = 16;
  localparam int unsigned XINIT_W = 12;
  localparam logic [XTOT_W-1:0]  XTOT_MAX  = '1;
  localparam logic [XINIT_W-1:0] XINIT_MAX = '1;

  // Result field widths
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned PIDX_W  = 16;
  localparam int unsigned PLVL_W  = 24;
  localparam int unsigned DECAY_W = 16;
  localparam int unsigned FREQ_W  = 17;

  localparam int unsigned M_FIELDS_W = PIDX_W + PLVL_W + DECAY_W + XTOT_W + XINIT_W + FREQ_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_TUSER_W  = CLASS_W + 1;

  // Exact integer forms of the fractional constants
  localparam int unsigned WINDOW_DIV  = 50;  // window = rate / 50
  localparam int unsigned THR_MUL     = 10;  // below threshold: 10*|x| < peak
  localparam int unsigned RATE_XMUL   = 5;   // high rate: 5*crossings > samples
  localparam int unsigned DECAY_MUL   = 20;  // short decay: 20*decay < 3*rate
  localparam int unsigned DECAY_RMUL  = 3;
  localparam int unsigned FREQ_MUL    = 25;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_HIHAT = 2'd0,
    CLASS_SNARE = 2'd1,
    CLASS_KICK  = 2'd2
  } drum_class_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_FIN
  } scan_state_e;

  typedef struct packed {
    logic                 en;
    logic [IDX_W_MAX-1:0] addr;
    logic [SMP_W_MAX-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [CNT_W_MAX-1:0] cnt;
    logic [IDX_W_MAX-1:0] peak_pos;
    logic [SMP_W_MAX-1:0] peak;
    logic [XTOT_W-1:0]    xtot;
    logic [XINIT_W-1:0]   xinit;
    logic                 ovf;
    logic [RATE_W-1:0]    rate;
  } job_t;

endpackage

### design/dha_front.sv
// ----------------------------------------------------------------------------
// dha_front - sample loader
// Accepts samples, writes them to the store, tracks the first peak and the
// sign changes, and hands a job descriptor to the scan engine on the last
// item of a hit.
// ----------------------------------------------------------------------------
module dha_front #(
  parameter int unsigned STORE_DEPTH = dha_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = dha_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [SAMPLE_BITS-1:0]    sample_i,
  input  logic                      last_i,
  input  logic                      busy_i,
  input  logic [dha_pkg::RATE_W-1:0] rate_i,
  output dha_pkg::mem_wr_t          mem_wr_o,
  output logic                      push_o,
  output dha_pkg::job_t             job_o
);
  import dha_pkg::*;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_upd;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d, peak_upd;
  logic [IDX_W-1:0]       pos_q, pos_d, pos_upd;
  logic                   neg_q, neg_d, neg_upd;
  logic [XTOT_W-1:0]      xtot_q, xtot_d, xtot_upd;
  logic [XINIT_W-1:0]     xinit_q, xinit_d, xinit_upd;
  logic                   ovf_q, ovf_d, ovf_upd;

  logic                   accept, full, neg, in_win;
  logic [SAMPLE_BITS-1:0] mag_x;
  logic [IDX_W-1:0]       idx;
  logic [31:0]            win_end;

  assign ready_o = !busy_i;
  assign accept  = valid_i && ready_o;
  assign full    = (cnt_q == CNT_W'(STORE_DEPTH));
  assign idx     = cnt_q[IDX_W-1:0];
  assign neg     = sample_i[SAMPLE_BITS-1];
  assign mag_x   = neg ? (~sample_i + 1'b1) : sample_i;

  // Inside the window when 50*(i+1) <= rate, i.e. i < rate/50 rounded down
  assign win_end = (32'(cnt_q) + 32'd1) * 32'(WINDOW_DIV);
  assign in_win  = (win_end <= 32'(rate_i));

  always_comb begin
    cnt_upd   = cnt_q;
    peak_upd  = peak_q;
    pos_upd   = pos_q;
    neg_upd   = neg_q;
    xtot_upd  = xtot_q;
    xinit_upd = xinit_q;
    ovf_upd   = ovf_q;
    if (accept) begin
      if (full) begin
        ovf_upd = 1'b1;
      end else begin
        cnt_upd = cnt_q + 1'b1;
        if (mag_x > peak_q) begin
          peak_upd = mag_x;
          pos_upd  = idx;
        end
        if (cnt_q != '0 && neg != neg_q) begin
          if (xtot_q != XTOT_MAX) xtot_upd = xtot_q + 1'b1;
          if (in_win && xinit_q != XINIT_MAX) xinit_upd = xinit_q + 1'b1;
        end
        neg_upd = neg;
      end
    end
  end

  assign push_o = accept && last_i;

  // Clear the hit state once its descriptor has gone
  assign cnt_d   = push_o ? '0   : cnt_upd;
  assign peak_d  = push_o ? '0   : peak_upd;
  assign pos_d   = push_o ? '0   : pos_upd;
  assign neg_d   = push_o ? 1'b0 : neg_upd;
  assign xtot_d  = push_o ? '0   : xtot_upd;
  assign xinit_d = push_o ? '0   : xinit_upd;
  assign ovf_d   = push_o ? 1'b0 : ovf_upd;

  always_comb begin
    job_o.cnt      = CNT_W_MAX'(cnt_upd);
    job_o.peak_pos = IDX_W_MAX'(pos_upd);
    job_o.peak     = SMP_W_MAX'(peak_upd);
    job_o.xtot     = xtot_upd;
    job_o.xinit    = xinit_upd;
    job_o.ovf      = ovf_upd;
    job_o.rate     = rate_i;
  end

  always_comb begin
    mem_wr_o.en   = accept && !full;
    mem_wr_o.addr = IDX_W_MAX'(idx);
    mem_wr_o.data = SMP_W_MAX'(sample_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      peak_q  <= '0;
      pos_q   <= '0;
      neg_q   <= 1'b0;
      xtot_q  <= '0;
      xinit_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      peak_q  <= peak_d;
      pos_q   <= pos_d;
      neg_q   <= neg_d;
      xtot_q  <= xtot_d;
      xinit_q <= xinit_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### design/dha_queue.sv
// ----------------------------------------------------------------------------
// dha_queue - job descriptor queue
// Short first-in first-out buffer of finished-hit descriptors between the
// loader and the scan engine.
// ----------------------------------------------------------------------------
module dha_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dha_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output dha_pkg::job_t job_o
);
  import dha_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              do_push, do_pop;

  assign do_push = push_i && (lvl_q != LVL_W'(QUEUE_DEPTH));
  assign do_pop  = pop_i && (lvl_q != '0);
  assign valid_o = (lvl_q != '0);
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    lvl_d    = lvl_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      lvl_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      lvl_q    <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_i;
  end

endmodule

### design/dha_back.sv
// ----------------------------------------------------------------------------
// dha_back - decay scan engine
// Holds the sample store. Takes a job, scans back from the last stored
// sample to the last one at or above a tenth of the peak, classifies the
// hit and loads the result register.
// ----------------------------------------------------------------------------
module dha_back #(
  parameter int unsigned STORE_DEPTH = dha_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = dha_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dha_pkg::mem_wr_t              mem_wr_i,
  input  logic                          job_valid_i,
  input  dha_pkg::job_t                 job_i,
  output logic                          pop_o,
  output logic                          busy_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [dha_pkg::M_TDATA_W-1:0] m_data_o,
  output logic [dha_pkg::M_TUSER_W-1:0] m_user_o
);
  import dha_pkg::*;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CMP_W = SAMPLE_BITS + 4;

  logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic                   rd_en;

  scan_state_e            state_q, state_d;
  job_t                   job_q, job_d;
  logic [IDX_W-1:0]       d_q, d_d;
  logic [IDX_W-1:0]       peak_pos;
  logic [SAMPLE_BITS-1:0] rd_mag;
  logic                   below;

  logic                   m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]   m_data_q, m_data_d;
  logic [M_TUSER_W-1:0]   m_user_q, m_user_d;
  logic                   out_load;

  logic [IDX_W-1:0]       decay;
  logic                   high_rate, short_decay;
  drum_class_e            cls;
  logic [FREQ_W-1:0]      freq;

  assign peak_pos = job_q.peak_pos[IDX_W-1:0];
  assign rd_mag   = rd_data_q[SAMPLE_BITS-1] ? (~rd_data_q + 1'b1) : rd_data_q;
  assign below    = (CMP_W'(rd_mag) * CMP_W'(THR_MUL)) < CMP_W'(job_q.peak[SAMPLE_BITS-1:0]);

  assign decay       = d_q - peak_pos;
  assign high_rate   = (32'(job_q.xtot) * 32'(RATE_XMUL)) > 32'(job_q.cnt);
  assign short_decay = (32'(decay) * 32'(DECAY_MUL)) < (32'(job_q.rate) * 32'(DECAY_RMUL));
  assign freq        = FREQ_W'(job_q.xinit) * FREQ_W'(FREQ_MUL);

  always_comb begin
    if (!high_rate) cls = CLASS_KICK;
    else if (short_decay) cls = CLASS_HIHAT;
    else cls = CLASS_SNARE;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign out_load = (state_q == S_FIN) && (!m_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    d_d     = d_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          d_d     = IDX_W'(job_i.cnt - 1'b1);
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (d_q > peak_pos) begin
          rd_en   = 1'b1;
          state_d = S_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CMP: begin
        if (below) begin
          d_d     = d_q - 1'b1;
          state_d = S_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_ready_i) m_valid_d = 1'b0;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = M_TDATA_W'({freq, job_q.xinit, job_q.xtot, DECAY_W'(decay),
                              PLVL_W'(job_q.peak[SAMPLE_BITS-1:0]), PIDX_W'(peak_pos)});
      m_user_d  = {job_q.ovf, cls};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    d_q      <= d_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) store[mem_wr_i.addr[IDX_W-1:0]] <= mem_wr_i.data[SAMPLE_BITS-1:0];
    if (rd_en) rd_data_q <= store[d_q];
  end

  a_scan_above_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (d_q > peak_pos))
    else $error("scan went below the peak index");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the finish step");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !mem_wr_i.en)
    else $error("store written during a scan");

endmodule

### design/drum_hit_analyzer.sv
// ----------------------------------------------------------------------------
// drum_hit_analyzer - attack, decay and crossing analysis of one drum hit
// Loads the samples of a hit, then classifies it as hi-hat, snare or kick.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one sample per item in tdata, tlast on the final
//   sample of a hit. Samples load at one per cycle while tready is high.
//   Samples beyond the store depth are dropped and flagged as overflow.
//   After the item with tlast the loader stalls (tready low) while the scan
//   engine takes the job and walks back from the last stored sample towards
//   the peak, reading each sample it passes over through the single store
//   read port and comparing it, and then finishes.
//   Output stream m_axis_*: one result item per hit, held in an output
//   register. The loader takes the next hit as soon as the result is in that
//   register, even while the receiver stalls; a second result waits in the
//   scan engine until the first is taken.
//   Sample rate register: cfg_wr_en_i / cfg_wr_data_i, write while idle.
//   Reset clears the hit state and the queue, sets the rate to 48000 Hz.
//   The store needs no clearing: only entries of the current hit are read.
// ----------------------------------------------------------------------------
module drum_hit_analyzer #(
  parameter int unsigned STORE_DEPTH = dha_pkg::STORE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = dha_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [dha_pkg::RATE_W-1:0]    cfg_wr_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [S_TDATA_W-1:0]          s_axis_tdata,  // sample
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // peak_index, peak_level, decay_samples, zero_crossings,
  // initial_crossings, base_freq_hz
  output logic [dha_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [dha_pkg::M_TUSER_W-1:0] m_axis_tuser   // drum_class, overflow
);
  import dha_pkg::*;

  logic [RATE_W-1:0] rate_q, rate_d;
  mem_wr_t           mem_wr;
  logic              push, pop, job_valid, back_busy, hit_busy;
  job_t              job_in, job_out;

  assign rate_d   = cfg_wr_en_i ? cfg_wr_data_i : rate_q;
  assign hit_busy = job_valid || back_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else begin
      rate_q <= rate_d;
    end
  end

  dha_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i   (s_axis_tlast),
    .busy_i   (hit_busy),
    .rate_i   (rate_q),
    .mem_wr_o (mem_wr),
    .push_o   (push),
    .job_o    (job_in)
  );

  dha_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  dha_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_wr_i    (mem_wr),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule
